>>> design/mbat_pkg.sv
// Package for the multicast block acknowledge tracker.
// Holds the field widths, codes, controller states and the command and status structs.
// Used by mbat_ctrl, mbat_dp and multicast_block_ack_tracker_core; depends on nothing.
package mbat_pkg;

    // Field widths.
    localparam int STATIONS  = 32;
    localparam int MASK_W    = 32;
    localparam int BLK_W     = 24;
    localparam int PCT_W     = 7;
    localparam int TMR_W     = 16;
    localparam int RTY_W     = 4;
    localparam int STA_W     = 5;
    localparam int OP_W      = 2;
    localparam int KIND_W    = 2;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Stations that exist; higher bits of a mask are ignored.
    localparam logic [MASK_W-1:0] VALID_STATIONS = (STATIONS >= MASK_W) ? '1 :
        MASK_W'((64'(1) << STATIONS) - 64'(1));

    // Percent divider: product of block index and 100, one quotient bit per step.
    localparam logic [PCT_W-1:0] PCT_FULL   = 7'd100;
    localparam int               PROD_W     = BLK_W + PCT_W;
    localparam int               DIV_CNT_W  = $clog2(PCT_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(PCT_W - 1);

    // Configuration reset values.
    localparam logic [TMR_W-1:0] TIMEOUT_RESET   = 16'd100;
    localparam logic [RTY_W-1:0] RETRY_RESET     = 4'd2;
    localparam logic [STA_W-1:0] IMAGE_ERR_RESET = 5'd0;

    typedef enum logic [OP_W-1:0] {
        OP_START  = 2'd0,
        OP_RESULT = 2'd1,
        OP_TICK   = 2'd2,
        OP_ABORT  = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_SEND   = 2'd0,
        KIND_RESEND = 2'd1,
        KIND_DONE   = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT     = 2'd0,
        CFG_RETRY_LIMIT = 2'd1,
        CFG_IMAGE_ERR   = 2'd2
    } cfg_idx_t;

    // Outcome of executing one input beat.
    typedef enum logic [1:0] {
        EXEC_NONE    = 2'd0,
        EXEC_ADVANCE = 2'd1,
        EXEC_EMIT    = 2'd2
    } exec_res_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_EXEC = 3'd1,
        ST_ADV  = 3'd2,
        ST_MUL  = 3'd3,
        ST_DIV  = 3'd4,
        ST_SEND = 3'd5,
        ST_OUT  = 3'd6
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic adv_check;
        logic mul;
        logic div_step;
        logic send;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        exec_res_t exec_res;
        logic      adv_finish;
        logic      div_done;
        logic      out_free;
    } dp_status_t;

endpackage

>>> design/multicast_block_ack_tracker_core.sv
// Multicast block acknowledge tracker, top level. Tracks one block-by-block broadcast
// to up to 32 stations: a start beat loads the station mask, the mode and the block
// total and sends block 0 unless the operation finishes at once; result beats collect
// acknowledgements and failures; tick beats run the confirm timer, resend to missing
// stations and drop them once the retry limit is reached; an abort beat ends a
// check-mode operation. Each input beat is handled alone: it is captured and executed;
// a resend or an abort result then goes to the output state; an advance checks whether
// the operation finishes, and if not, the percent divider runs, producing one quotient
// bit per cycle, before the new block is sent. A result sits in an output register, so
// the next input beat is taken while it waits; a beat that makes a result stalls in its
// output state for as long as the output register still holds an earlier result that has not been taken.
// Depends on mbat_pkg, mbat_ctrl and mbat_dp.
module multicast_block_ack_tracker_core
    import mbat_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [OP_W-1:0]      s_op,
    input  logic [MASK_W-1:0]    s_station_mask,
    input  logic                 s_write_mode,
    input  logic [BLK_W-1:0]     s_block_total,
    input  logic [STA_W-1:0]     s_station,
    input  logic                 s_result_ok,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [KIND_W-1:0]    m_kind,
    output logic [MASK_W-1:0]    m_dest_mask,
    output logic [BLK_W-1:0]     m_block_index,
    output logic                 m_block_write,
    output logic [PCT_W-1:0]     m_percent,
    output logic [MASK_W-1:0]    m_error_mask,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencing.
    mbat_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // State, divider and output register.
    mbat_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_op           (s_op),
        .s_station_mask (s_station_mask),
        .s_write_mode   (s_write_mode),
        .s_block_total  (s_block_total),
        .s_station      (s_station),
        .s_result_ok    (s_result_ok),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_dest_mask    (m_dest_mask),
        .m_block_index  (m_block_index),
        .m_block_write  (m_block_write),
        .m_percent      (m_percent),
        .m_error_mask   (m_error_mask),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

endmodule

>>> design/mbat_ctrl.sv
// Controller state machine of the multicast block acknowledge tracker.
// Sequences capture, execution, block advance, percent division and result output.
// Depends on mbat_pkg.
module mbat_ctrl
    import mbat_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                case (status.exec_res)
                    EXEC_ADVANCE: state_next = ST_ADV;
                    EXEC_EMIT:    state_next = ST_OUT;
                    default:      state_next = ST_IDLE;
                endcase
            end
            ST_ADV: begin
                // Either the operation finishes here or the next block is prepared.
                cmd.adv_check = 1'b1;
                state_next    = status.adv_finish ? ST_OUT : ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_done) begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND: begin
                cmd.send   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // Wait until the output register can take the pending result.
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/mbat_dp.sv
// Datapath of the multicast block acknowledge tracker.
// Holds configuration, tracking state, the percent divider and the output register.
// Depends on mbat_pkg; driven by commands from mbat_ctrl.
module mbat_dp
    import mbat_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    input  logic [OP_W-1:0]      s_op,
    input  logic [MASK_W-1:0]    s_station_mask,
    input  logic                 s_write_mode,
    input  logic [BLK_W-1:0]     s_block_total,
    input  logic [STA_W-1:0]     s_station,
    input  logic                 s_result_ok,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [KIND_W-1:0]    m_kind,
    output logic [MASK_W-1:0]    m_dest_mask,
    output logic [BLK_W-1:0]     m_block_index,
    output logic                 m_block_write,
    output logic [PCT_W-1:0]     m_percent,
    output logic [MASK_W-1:0]    m_error_mask,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Configuration registers.
    logic [TMR_W-1:0] timeout_reg;
    logic [RTY_W-1:0] retry_limit_reg;
    logic [STA_W-1:0] image_err_reg;

    // Captured input beat.
    op_t              in_op_reg;
    logic [MASK_W-1:0] in_mask_reg;
    logic             in_write_reg;
    logic [BLK_W-1:0] in_total_reg;
    logic [STA_W-1:0] in_station_reg;
    logic             in_ok_reg;

    // Tracking state.
    logic              active_reg, active_next;
    logic              mode_reg, mode_next;
    logic [MASK_W-1:0] live_reg, live_next;
    logic [MASK_W-1:0] acked_reg, acked_next;
    logic [MASK_W-1:0] failed_reg, failed_next;
    logic [BLK_W-1:0]  next_blk_reg, next_blk_next;
    logic [BLK_W-1:0]  total_reg, total_next;
    logic [TMR_W-1:0]  timer_reg, timer_next;
    logic [RTY_W-1:0]  retries_reg, retries_next;
    logic [PCT_W-1:0]  progress_reg, progress_next;

    // Percent divider.
    logic [PROD_W-1:0]    rem_reg, rem_next;
    logic [PROD_W-1:0]    dvs_reg, dvs_next;
    logic [PCT_W-1:0]     quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    // Pending result.
    kind_t             res_kind_reg, res_kind_next;
    logic [MASK_W-1:0] res_dest_reg, res_dest_next;
    logic [BLK_W-1:0]  res_blk_reg, res_blk_next;
    logic              res_write_reg, res_write_next;
    logic [PCT_W-1:0]  res_pct_reg, res_pct_next;
    logic [MASK_W-1:0] res_err_reg, res_err_next;

    // Output register.
    logic              m_valid_reg, m_valid_next;
    kind_t             m_kind_reg;
    logic [MASK_W-1:0] m_dest_reg;
    logic [BLK_W-1:0]  m_blk_reg;
    logic              m_write_reg;
    logic [PCT_W-1:0]  m_pct_reg;
    logic [MASK_W-1:0] m_err_reg;

    logic [MASK_W-1:0] sta_bit;
    logic [MASK_W-1:0] img_bit;
    logic [MASK_W-1:0] missing;
    logic [RTY_W-1:0]  retries_inc;
    logic [PCT_W-1:0]  pct_new;
    exec_res_t         exec_res;
    logic              adv_finish;

    assign sta_bit     = MASK_W'(1) << in_station_reg;
    assign img_bit     = MASK_W'(1) << image_err_reg;
    assign missing     = live_reg & ~acked_reg;
    assign retries_inc = retries_reg + RTY_W'(1);
    assign pct_new     = (quo_reg > progress_reg) ? quo_reg : progress_reg;
    assign adv_finish  = (live_reg == '0) || (next_blk_reg >= total_reg);

    assign status.exec_res   = exec_res;
    assign status.adv_finish = adv_finish;
    assign status.div_done   = (cnt_reg == DIV_LAST);
    assign status.out_free   = !m_valid_reg || m_ready;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg     <= TIMEOUT_RESET;
            retry_limit_reg <= RETRY_RESET;
            image_err_reg   <= IMAGE_ERR_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_TIMEOUT:     timeout_reg     <= cfg_data[TMR_W-1:0];
                CFG_RETRY_LIMIT: retry_limit_reg <= cfg_data[RTY_W-1:0];
                CFG_IMAGE_ERR:   image_err_reg   <= cfg_data[STA_W-1:0];
                default: ;
            endcase
        end
    end

    // Input beat capture.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_op_reg      <= op_t'(s_op);
            in_mask_reg    <= s_station_mask;
            in_write_reg   <= s_write_mode;
            in_total_reg   <= s_block_total;
            in_station_reg <= s_station;
            in_ok_reg      <= s_result_ok;
        end
    end

    // Next values of the tracking state, divider and pending result.
    always_comb begin
        active_next    = active_reg;
        mode_next      = mode_reg;
        live_next      = live_reg;
        acked_next     = acked_reg;
        failed_next    = failed_reg;
        next_blk_next  = next_blk_reg;
        total_next     = total_reg;
        timer_next     = timer_reg;
        retries_next   = retries_reg;
        progress_next  = progress_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        res_kind_next  = res_kind_reg;
        res_dest_next  = res_dest_reg;
        res_blk_next   = res_blk_reg;
        res_write_next = res_write_reg;
        res_pct_next   = res_pct_reg;
        res_err_next   = res_err_reg;
        exec_res       = EXEC_NONE;

        // Execute the captured beat.
        if (cmd.exec) begin
            case (in_op_reg)
                OP_START: begin
                    if (!active_reg) begin
                        active_next   = 1'b1;
                        mode_next     = in_write_reg;
                        live_next     = in_mask_reg & VALID_STATIONS;
                        acked_next    = in_mask_reg & VALID_STATIONS;
                        failed_next   = '0;
                        total_next    = in_total_reg;
                        next_blk_next = '0;
                        progress_next = '0;
                        timer_next    = '0;
                        retries_next  = '0;
                        exec_res      = EXEC_ADVANCE;
                    end
                end
                OP_RESULT: begin
                    // Reports from dropped or absent stations are ignored.
                    if (active_reg && ((sta_bit & VALID_STATIONS & live_reg) != '0)) begin
                        if (in_ok_reg) begin
                            acked_next = acked_reg | sta_bit;
                        end else begin
                            failed_next = failed_reg | sta_bit;
                            live_next   = live_reg & ~sta_bit;
                            acked_next  = acked_reg & ~sta_bit;
                        end
                        if ((acked_next & live_next) == live_next) begin
                            exec_res = EXEC_ADVANCE;
                        end
                    end
                end
                OP_TICK: begin
                    if (active_reg) begin
                        if (timer_reg > TMR_W'(1)) begin
                            timer_next = timer_reg - TMR_W'(1);
                        end else begin
                            timer_next   = '0;
                            retries_next = retries_inc;
                            if (retries_inc < retry_limit_reg) begin
                                // Resend the current block to the stations still missing.
                                timer_next     = timeout_reg;
                                res_kind_next  = KIND_RESEND;
                                res_dest_next  = missing;
                                res_blk_next   = next_blk_reg - BLK_W'(1);
                                res_write_next = mode_reg;
                                res_pct_next   = progress_reg;
                                res_err_next   = '0;
                                exec_res       = EXEC_EMIT;
                            end else begin
                                // Retries used up: missing stations fail and are dropped.
                                failed_next = failed_reg | missing;
                                live_next   = live_reg & acked_reg;
                                exec_res    = EXEC_ADVANCE;
                            end
                        end
                    end
                end
                OP_ABORT: begin
                    // Abort only takes effect in check mode.
                    if (active_reg && !mode_reg) begin
                        active_next    = 1'b0;
                        progress_next  = '0;
                        res_kind_next  = KIND_DONE;
                        res_dest_next  = '0;
                        res_blk_next   = '0;
                        res_write_next = mode_reg;
                        res_pct_next   = '0;
                        res_err_next   = '1;
                        exec_res       = EXEC_EMIT;
                    end
                end
                default: ;
            endcase
        end

        // Finish when no station is left or every block has been sent.
        if (cmd.adv_check && adv_finish) begin
            if ((live_reg != '0) && (total_reg == '0)) begin
                failed_next  = failed_reg | img_bit;
                res_err_next = failed_reg | img_bit;
            end else begin
                res_err_next = failed_reg;
            end
            active_next    = 1'b0;
            res_kind_next  = KIND_DONE;
            res_dest_next  = '0;
            res_blk_next   = '0;
            res_write_next = mode_reg;
            res_pct_next   = progress_reg;
        end

        // Load the dividend and the divisor aligned to the top quotient bit.
        if (cmd.mul) begin
            rem_next = PROD_W'(next_blk_reg) * PROD_W'(PCT_FULL);
            dvs_next = PROD_W'(total_reg) << (PCT_W - 1);
            quo_next = '0;
            cnt_next = '0;
        end

        // One restoring division step per cycle.
        if (cmd.div_step) begin
            if (rem_reg >= dvs_reg) begin
                rem_next = rem_reg - dvs_reg;
                quo_next = {quo_reg[PCT_W-2:0], 1'b1};
            end else begin
                quo_next = {quo_reg[PCT_W-2:0], 1'b0};
            end
            dvs_next = dvs_reg >> 1;
            cnt_next = cnt_reg + DIV_CNT_W'(1);
        end

        // Send the next block to all live stations.
        if (cmd.send) begin
            progress_next  = pct_new;
            next_blk_next  = next_blk_reg + BLK_W'(1);
            acked_next     = '0;
            timer_next     = timeout_reg;
            retries_next   = '0;
            res_kind_next  = KIND_SEND;
            res_dest_next  = live_reg;
            res_blk_next   = next_blk_reg;
            res_write_next = mode_reg;
            res_pct_next   = pct_new;
            res_err_next   = '0;
        end
    end

    // Tracking state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            mode_reg     <= 1'b0;
            live_reg     <= '0;
            acked_reg    <= '0;
            failed_reg   <= '0;
            next_blk_reg <= '0;
            total_reg    <= '0;
            timer_reg    <= '0;
            retries_reg  <= '0;
            progress_reg <= '0;
        end else begin
            active_reg   <= active_next;
            mode_reg     <= mode_next;
            live_reg     <= live_next;
            acked_reg    <= acked_next;
            failed_reg   <= failed_next;
            next_blk_reg <= next_blk_next;
            total_reg    <= total_next;
            timer_reg    <= timer_next;
            retries_reg  <= retries_next;
            progress_reg <= progress_next;
        end
    end

    // Divider and pending result registers.
    always_ff @(posedge aclk) begin
        rem_reg       <= rem_next;
        dvs_reg       <= dvs_next;
        quo_reg       <= quo_next;
        cnt_reg       <= cnt_next;
        res_kind_reg  <= res_kind_next;
        res_dest_reg  <= res_dest_next;
        res_blk_reg   <= res_blk_next;
        res_write_reg <= res_write_next;
        res_pct_reg   <= res_pct_next;
        res_err_reg   <= res_err_next;
    end

    // Output valid: set on load, cleared when the beat is taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_kind_reg  <= res_kind_reg;
            m_dest_reg  <= res_dest_reg;
            m_blk_reg   <= res_blk_reg;
            m_write_reg <= res_write_reg;
            m_pct_reg   <= res_pct_reg;
            m_err_reg   <= res_err_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_dest_mask   = m_dest_reg;
    assign m_block_index = m_blk_reg;
    assign m_block_write = m_write_reg;
    assign m_percent     = m_pct_reg;
    assign m_error_mask  = m_err_reg;

endmodule
